// ----- design/pod_pkg.sv -----
// Shared types and constants for the parking occupancy detector.
package pod_pkg;

	localparam int DIST_W = 14;
	localparam int DEB_W = 8;
	localparam int LIMIT_W = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NEAR_LIMIT   = 3'd0,
		REG_MIN_DIST     = 3'd1,
		REG_MAX_DIST     = 3'd2,
		REG_DEBOUNCE     = 3'd3,
		REG_MAG_LIMIT_X  = 3'd4,
		REG_MAG_LIMIT_Y  = 3'd5,
		REG_MAG_LIMIT_Z  = 3'd6
	} reg_idx_t;

	localparam logic [DIST_W-1:0] NEAR_LIMIT_RST = 14'd1600;
	localparam logic [DIST_W-1:0] MIN_DIST_RST = 14'd16;
	localparam logic [DIST_W-1:0] MAX_DIST_RST = 14'd8000;
	localparam logic [DEB_W-1:0] DEBOUNCE_RST = 8'd3;
	localparam logic [LIMIT_W-1:0] MAG_LIMIT_X_RST = 16'd100;
	localparam logic [LIMIT_W-1:0] MAG_LIMIT_Y_RST = 16'd49;
	localparam logic [LIMIT_W-1:0] MAG_LIMIT_Z_RST = 16'd349;

	typedef struct packed {
		logic [DIST_W-1:0]  near_limit;
		logic [DIST_W-1:0]  min_valid_distance;
		logic [DIST_W-1:0]  max_valid_distance;
		logic [DEB_W-1:0]   debounce_count;
		logic [LIMIT_W-1:0] mag_limit_x;
		logic [LIMIT_W-1:0] mag_limit_y;
		logic [LIMIT_W-1:0] mag_limit_z;
	} cfg_t;

	typedef struct packed {
		logic occupied;
		logic used_magnetic;
		logic magnetic_event;
		logic baseline_captured;
		logic state_changed;
	} result_t;

	typedef struct packed {
		logic latched_full;
		logic latched_empty;
		logic occupied_flag;
	} latch_t;

endpackage

// ----- design/pod_step.sv -----
// Per-sample decision logic: next detector state and result flags.
module pod_step #(
	parameter int RUN_COUNT_WIDTH = 8,
	parameter int FIELD_WIDTH = 16
) (
	input  pod_pkg::cfg_t                cfg,
	input  logic [pod_pkg::DIST_W-1:0]   distance,
	input  logic                         distance_nan,
	input  logic [FIELD_WIDTH-1:0]       field_x,
	input  logic [FIELD_WIDTH-1:0]       field_y,
	input  logic [FIELD_WIDTH-1:0]       field_z,
	input  logic [RUN_COUNT_WIDTH-1:0]   near_run,
	input  logic [RUN_COUNT_WIDTH-1:0]   far_run,
	input  pod_pkg::latch_t              latch,
	input  logic [FIELD_WIDTH-1:0]       base_x,
	input  logic [FIELD_WIDTH-1:0]       base_y,
	input  logic [FIELD_WIDTH-1:0]       base_z,
	output logic [RUN_COUNT_WIDTH-1:0]   near_run_nxt,
	output logic [RUN_COUNT_WIDTH-1:0]   far_run_nxt,
	output pod_pkg::latch_t              latch_nxt,
	output logic                         base_load,
	output pod_pkg::result_t             result
);

	localparam int DIFF_W = FIELD_WIDTH + 1;
	localparam int CMP_W = (DIFF_W > pod_pkg::LIMIT_W) ? DIFF_W : pod_pkg::LIMIT_W;
	localparam int RCMP_W = (RUN_COUNT_WIDTH > pod_pkg::DEB_W) ? RUN_COUNT_WIDTH
		: pod_pkg::DEB_W;
	localparam logic [RUN_COUNT_WIDTH-1:0] RUN_MAX = {RUN_COUNT_WIDTH{1'b1}};

	logic failed;
	logic near;
	logic capture;
	logic event_hit;
	logic [DIFF_W-1:0] mag_x, mag_y, mag_z;
	logic [RCMP_W-1:0] deb_ext;

	// Magnitude of baseline minus reading, one extra bit for the full swing.
	function automatic logic [DIFF_W-1:0] abs_diff(input logic [FIELD_WIDTH-1:0] a,
		input logic [FIELD_WIDTH-1:0] b);
		logic [DIFF_W-1:0] d;
		d = {a[FIELD_WIDTH-1], a} - {b[FIELD_WIDTH-1], b};
		return d[DIFF_W-1] ? (~d + 1'b1) : d;
	endfunction

	assign failed = distance_nan || (distance <= cfg.min_valid_distance)
		|| (distance > cfg.max_valid_distance);
	assign near = distance < cfg.near_limit;
	assign deb_ext = RCMP_W'(cfg.debounce_count);

	assign mag_x = abs_diff(base_x, field_x);
	assign mag_y = abs_diff(base_y, field_y);
	assign mag_z = abs_diff(base_z, field_z);

	assign capture = (!latch.latched_empty && !latch.latched_full)
		|| (base_x == '0 && base_y == '0 && base_z == '0);
	assign event_hit = (CMP_W'(mag_x) > CMP_W'(cfg.mag_limit_x))
		|| (CMP_W'(mag_y) > CMP_W'(cfg.mag_limit_y))
		|| (CMP_W'(mag_z) > CMP_W'(cfg.mag_limit_z));

	always_comb begin
		near_run_nxt = near_run;
		far_run_nxt = far_run;
		latch_nxt = latch;
		base_load = 1'b0;
		result = '0;
		if (!failed) begin
			if (near) begin
				near_run_nxt = (near_run == RUN_MAX) ? RUN_MAX : near_run + 1'b1;
				far_run_nxt = '0;
			end else begin
				near_run_nxt = '0;
				far_run_nxt = (far_run == RUN_MAX) ? RUN_MAX : far_run + 1'b1;
			end
			if (RCMP_W'(near_run_nxt) > deb_ext && !latch.latched_full) begin
				latch_nxt = '{latched_full: 1'b1, latched_empty: 1'b0, occupied_flag: 1'b1};
			end
			if (RCMP_W'(far_run_nxt) > deb_ext && !latch.latched_empty) begin
				latch_nxt = '{latched_full: 1'b0, latched_empty: 1'b1, occupied_flag: 1'b0};
			end
		end else begin
			result.used_magnetic = 1'b1;
			if (capture) begin
				base_load = 1'b1;
				result.baseline_captured = 1'b1;
			end else if (event_hit) begin
				base_load = 1'b1;
				result.magnetic_event = 1'b1;
				if (!latch.latched_full && latch.latched_empty) begin
					latch_nxt = '{latched_full: 1'b1, latched_empty: 1'b0,
						occupied_flag: 1'b1};
				end else if (latch.latched_full && !latch.latched_empty) begin
					latch_nxt = '{latched_full: 1'b0, latched_empty: 1'b1,
						occupied_flag: 1'b0};
				end
			end
		end
		result.occupied = latch_nxt.occupied_flag;
		result.state_changed = latch_nxt.occupied_flag ^ latch.occupied_flag;
	end

endmodule

// ----- design/parking_occupancy_detector_core.sv -----
// Top level of the parking occupancy detector: channels, config and state registers.
//
//  channel   | handshake                     | payload
//  ----------+-------------------------------+------------------------------------------
//  sample    | sample_valid / sample_ready   | distance, distance_nan, field_x/y/z
//  result    | result_valid / result_ready   | occupied, used_magnetic, magnetic_event,
//            |                               | baseline_captured, state_changed
//  config    | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// One sample per clock while the result register is free or being taken. A transfer on
// the sample side lands in the input register; the decision logic runs on it against the
// detector state, and the result register and the state update together as it moves on.
// The input register holds while the result register is full and not taken; the sample
// side stalls only then. Reset loads the register defaults, clears the run counters and
// baseline, and marks the spot free. cfg_ready is always high.
module parking_occupancy_detector_core #(
	parameter int RUN_COUNT_WIDTH = 8,
	parameter int FIELD_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_ready,
	input  logic [pod_pkg::DIST_W-1:0]        distance,
	input  logic                              distance_nan,
	input  logic [FIELD_WIDTH-1:0]            field_x,
	input  logic [FIELD_WIDTH-1:0]            field_y,
	input  logic [FIELD_WIDTH-1:0]            field_z,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic                              occupied,
	output logic                              used_magnetic,
	output logic                              magnetic_event,
	output logic                              baseline_captured,
	output logic                              state_changed,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pod_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pod_pkg::CFG_DATA_W-1:0]    cfg_data
);

	pod_pkg::cfg_t cfg_q;

	// input stage
	logic                        valid_s1;
	logic [pod_pkg::DIST_W-1:0]  distance_s1;
	logic                        nan_s1;
	logic [FIELD_WIDTH-1:0]      field_x_s1, field_y_s1, field_z_s1;

	// detector state
	logic [RUN_COUNT_WIDTH-1:0]  near_run_q, far_run_q;
	pod_pkg::latch_t             latch_q;
	logic [FIELD_WIDTH-1:0]      base_x_q, base_y_q, base_z_q;

	// result stage
	logic                        valid_s2;
	pod_pkg::result_t            result_s2;

	logic [RUN_COUNT_WIDTH-1:0]  near_run_nxt, far_run_nxt;
	pod_pkg::latch_t             latch_nxt;
	logic                        base_load;
	pod_pkg::result_t            result_nxt;
	logic                        advance;

	// Move the held sample into the result register when that register is free or
	// being drained this cycle.
	assign advance = valid_s1 && (!valid_s2 || result_ready);
	assign sample_ready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// Config writes; indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.near_limit <= pod_pkg::NEAR_LIMIT_RST;
			cfg_q.min_valid_distance <= pod_pkg::MIN_DIST_RST;
			cfg_q.max_valid_distance <= pod_pkg::MAX_DIST_RST;
			cfg_q.debounce_count <= pod_pkg::DEBOUNCE_RST;
			cfg_q.mag_limit_x <= pod_pkg::MAG_LIMIT_X_RST;
			cfg_q.mag_limit_y <= pod_pkg::MAG_LIMIT_Y_RST;
			cfg_q.mag_limit_z <= pod_pkg::MAG_LIMIT_Z_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				pod_pkg::REG_NEAR_LIMIT:
					cfg_q.near_limit <= cfg_data[pod_pkg::DIST_W-1:0];
				pod_pkg::REG_MIN_DIST:
					cfg_q.min_valid_distance <= cfg_data[pod_pkg::DIST_W-1:0];
				pod_pkg::REG_MAX_DIST:
					cfg_q.max_valid_distance <= cfg_data[pod_pkg::DIST_W-1:0];
				pod_pkg::REG_DEBOUNCE:
					cfg_q.debounce_count <= cfg_data[pod_pkg::DEB_W-1:0];
				pod_pkg::REG_MAG_LIMIT_X:
					cfg_q.mag_limit_x <= cfg_data[pod_pkg::LIMIT_W-1:0];
				pod_pkg::REG_MAG_LIMIT_Y:
					cfg_q.mag_limit_y <= cfg_data[pod_pkg::LIMIT_W-1:0];
				pod_pkg::REG_MAG_LIMIT_Z:
					cfg_q.mag_limit_z <= cfg_data[pod_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register: capture on a sample transfer, drop the valid once passed on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_valid && sample_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			distance_s1 <= distance;
			nan_s1 <= distance_nan;
			field_x_s1 <= field_x;
			field_y_s1 <= field_y;
			field_z_s1 <= field_z;
		end
	end

	pod_step #(
		.RUN_COUNT_WIDTH(RUN_COUNT_WIDTH),
		.FIELD_WIDTH(FIELD_WIDTH)
	) u_step (
		.cfg(cfg_q),
		.distance(distance_s1),
		.distance_nan(nan_s1),
		.field_x(field_x_s1),
		.field_y(field_y_s1),
		.field_z(field_z_s1),
		.near_run(near_run_q),
		.far_run(far_run_q),
		.latch(latch_q),
		.base_x(base_x_q),
		.base_y(base_y_q),
		.base_z(base_z_q),
		.near_run_nxt(near_run_nxt),
		.far_run_nxt(far_run_nxt),
		.latch_nxt(latch_nxt),
		.base_load(base_load),
		.result(result_nxt)
	);

	// Advance the detector state exactly once per sample, as it enters the result
	// register; the next sample then sees it without a gap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_run_q <= '0;
			far_run_q <= '0;
			latch_q <= '{latched_full: 1'b0, latched_empty: 1'b1, occupied_flag: 1'b0};
			base_x_q <= '0;
			base_y_q <= '0;
			base_z_q <= '0;
		end else if (advance) begin
			near_run_q <= near_run_nxt;
			far_run_q <= far_run_nxt;
			latch_q <= latch_nxt;
			if (base_load) begin
				base_x_q <= field_x_s1;
				base_y_q <= field_y_s1;
				base_z_q <= field_z_s1;
			end
		end
	end

	// Result register: hold until the result transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_nxt;
		end
	end

	assign result_valid = valid_s2;
	assign occupied = result_s2.occupied;
	assign used_magnetic = result_s2.used_magnetic;
	assign magnetic_event = result_s2.magnetic_event;
	assign baseline_captured = result_s2.baseline_captured;
	assign state_changed = result_s2.state_changed;

endmodule
